FILE: design/cfe_pkg.sv
// Shared types and constants for the COBS frame encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps

package cfe_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int LEN_BOUND_INT   = MAX_FRAME_BYTES + (MAX_FRAME_BYTES + 253) / 254 + 1;
  localparam int IDX_W           = 13;

  localparam logic [IDX_W-1:0] LEN_BOUND = IDX_W'(LEN_BOUND_INT);
  localparam logic [IDX_W-1:0] ADDR_MAX  = IDX_W'(LEN_BOUND_INT - 1);

  localparam logic [7:0] CODE_START = 8'h01;
  localparam logic [7:0] CODE_FULL  = 8'hFF;

  // result step within one input beat
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_FULL  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } cfe_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] write_addr;
    logic [7:0]       write_byte;
    logic             run_end;
    logic             frame_end;
    logic [IDX_W-1:0] frame_length;
    logic             overflow;
  } cfe_out_t;

  typedef struct packed {
    logic fire;
    logic item_done;
  } cfe_ctl_t;

endpackage

FILE: design/cfe_in_reg.sv
// Input holding register for the COBS frame encoder.
// Depends on cfe_pkg; released by the step logic in cfe_encode.
`timescale 1ns / 1ps

module cfe_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cfe_pkg::cfe_in_t in_data,
  input  cfe_pkg::cfe_ctl_t ctl,
  output logic             item_valid,
  output cfe_pkg::cfe_in_t item
);

  logic             hold_valid_r;
  logic             hold_valid_nxt;
  cfe_pkg::cfe_in_t hold_r;
  logic             accept;

  assign in_stall   = hold_valid_r && !(ctl.fire && ctl.item_done);
  assign accept     = in_valid && !in_stall;
  assign item_valid = hold_valid_r;
  assign item       = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (ctl.fire && ctl.item_done) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_data;
    end
  end

endmodule

FILE: design/cfe_encode.sv
// Encoder state and per-write step logic: one addressed write per firing.
// Depends on cfe_pkg; fed by cfe_in_reg, drains into cfe_out_reg.
`timescale 1ns / 1ps

module cfe_encode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  cfe_pkg::cfe_in_t   item,
  input  logic               out_ready,
  output cfe_pkg::cfe_ctl_t  ctl,
  output cfe_pkg::cfe_out_t  result
);

  logic [cfe_pkg::IDX_W-1:0] nwi_r, nwi_nxt;
  logic [cfe_pkg::IDX_W-1:0] csi_r, csi_nxt;
  logic [7:0]                bc_r, bc_nxt;
  logic                      ov_r, ov_nxt;
  logic [1:0]                phase_r, phase_nxt;

  logic                      fire;
  logic                      is_zero;
  logic                      data_wr;
  logic [cfe_pkg::IDX_W-1:0] raw_addr;
  logic                      addr_hit;
  logic                      ov_emit;
  logic [7:0]                bc_inc;
  logic                      adv_ok;
  logic [cfe_pkg::IDX_W-1:0] nwi_adv;
  logic                      ov_adv;
  logic                      done;
  logic [1:0]                step_next;

  assign fire    = item_valid && out_ready;
  assign is_zero = (item.data_byte == 8'h00);
  assign data_wr = (phase_r == cfe_pkg::PH_FIRST) && !is_zero;

  always_comb begin
    raw_addr = data_wr ? nwi_r : csi_r;
    addr_hit = raw_addr > cfe_pkg::ADDR_MAX;
    ov_emit  = ov_r || addr_hit;
    bc_inc   = bc_r + 8'd1;
    adv_ok   = nwi_r < cfe_pkg::LEN_BOUND;
    nwi_adv  = adv_ok ? nwi_r + cfe_pkg::IDX_W'(1) : nwi_r;
    ov_adv   = ov_emit || !adv_ok;
  end

  always_comb begin
    done      = 1'b1;
    step_next = cfe_pkg::PH_FIRST;
    case (phase_r)
      cfe_pkg::PH_FIRST: begin
        if (!is_zero && bc_inc == cfe_pkg::CODE_FULL) begin
          done      = 1'b0;
          step_next = cfe_pkg::PH_FULL;
        end else if (item.final_byte) begin
          done      = 1'b0;
          step_next = cfe_pkg::PH_FINAL;
        end
      end
      cfe_pkg::PH_FULL: begin
        if (item.final_byte) begin
          done      = 1'b0;
          step_next = cfe_pkg::PH_FINAL;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    nwi_nxt   = nwi_r;
    csi_nxt   = csi_r;
    bc_nxt    = bc_r;
    ov_nxt    = ov_r;
    phase_nxt = phase_r;
    if (fire) begin
      phase_nxt = done ? cfe_pkg::PH_FIRST : step_next;
      case (phase_r)
        cfe_pkg::PH_FIRST: begin
          nwi_nxt = nwi_adv;
          ov_nxt  = ov_adv;
          if (is_zero) begin
            csi_nxt = nwi_r;
            bc_nxt  = cfe_pkg::CODE_START;
          end else begin
            bc_nxt  = bc_inc;
          end
        end
        cfe_pkg::PH_FULL: begin
          nwi_nxt = nwi_adv;
          ov_nxt  = ov_adv;
          csi_nxt = nwi_r;
          bc_nxt  = cfe_pkg::CODE_START;
        end
        cfe_pkg::PH_FINAL: begin
          nwi_nxt = cfe_pkg::IDX_W'(1);
          csi_nxt = '0;
          bc_nxt  = cfe_pkg::CODE_START;
          ov_nxt  = 1'b0;
        end
        default: begin
          phase_nxt = cfe_pkg::PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nwi_r   <= cfe_pkg::IDX_W'(1);
      csi_r   <= '0;
      bc_r    <= cfe_pkg::CODE_START;
      ov_r    <= 1'b0;
      phase_r <= cfe_pkg::PH_FIRST;
    end else begin
      nwi_r   <= nwi_nxt;
      csi_r   <= csi_nxt;
      bc_r    <= bc_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign ctl.fire      = fire;
  assign ctl.item_done = done;

  always_comb begin
    result.write_addr   = addr_hit ? cfe_pkg::ADDR_MAX : raw_addr;
    result.write_byte   = data_wr ? item.data_byte : bc_r;
    result.run_end      = done;
    result.frame_end    = (phase_r == cfe_pkg::PH_FINAL);
    result.frame_length = (phase_r == cfe_pkg::PH_FINAL) ? nwi_r : '0;
    result.overflow     = ov_emit;
  end

endmodule

FILE: design/cfe_out_reg.sv
// Result register for the COBS frame encoder output channel.
// Depends on cfe_pkg; loaded from cfe_encode.
`timescale 1ns / 1ps

module cfe_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cfe_pkg::cfe_out_t result,
  output logic              out_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output cfe_pkg::cfe_out_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  cfe_pkg::cfe_out_t data_r;

  assign out_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fire) begin
      data_r <= result;
    end
  end

endmodule

FILE: design/cobs_frame_encoder_core.sv
// COBS frame encoder top level: one raw byte per input beat, addressed writes out.
// Depends on cfe_pkg, cfe_in_reg, cfe_encode and cfe_out_reg.
`timescale 1ns / 1ps

// Each input beat yields one to three output beats, one per cycle unless the
// output stalls: a nonzero byte gives its data write, a zero byte a code write
// at the code slot, a block reaching code 0xFF adds a code write, and a byte
// flagged final adds the frame's closing code write carrying frame_length. An
// input beat thus occupies the encoder until the single result register has
// taken all its writes; plain data bytes stream at one beat per cycle unless stalled.
// Addresses saturate at the encoded-length bound with a sticky overflow flag
// that clears at frame end. Beats wait in cfe_in_reg, writes in cfe_out_reg.

module cobs_frame_encoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfe_pkg::cfe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cfe_pkg::cfe_out_t out_data
);

  cfe_pkg::cfe_ctl_t ctl;
  logic              item_valid;
  cfe_pkg::cfe_in_t  item;
  logic              out_ready;
  cfe_pkg::cfe_out_t result;

  cfe_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  cfe_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .ctl        (ctl),
    .result     (result)
  );

  cfe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (ctl.fire),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/cfe_write_checker.sv
// Scoreboard for the COBS frame encoder: predicts the addressed writes for every
// accepted input beat and compares each accepted output beat with them in order.
// Depends on cfe_pkg for the beat types and the encoded-length bound.
`timescale 1ns / 1ps

module cfe_write_checker
  import cfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  cfe_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  cfe_out_t out_data,
  output int       fail_count,
  output int       writes_pending,
  output int       writes_checked,
  output int       overflow_frames
);

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] slot_idx;
  logic [7:0]       blk_code;
  logic             ovf_seen;
  cfe_out_t         expected_writes[$];

  function automatic cfe_out_t make_write(input logic [IDX_W-1:0] addr, input logic [7:0] val,
                                          input logic fend, input logic [IDX_W-1:0] flen);
    cfe_out_t w;
    if (addr > ADDR_MAX) begin
      ovf_seen = 1'b1;
      addr = ADDR_MAX;
    end
    w.write_addr   = addr;
    w.write_byte   = val;
    w.run_end      = 1'b0;
    w.frame_end    = fend;
    w.frame_length = flen;
    w.overflow     = ovf_seen;
    return w;
  endfunction

  function automatic void bump_index();
    if (wr_idx < LEN_BOUND) begin
      wr_idx = wr_idx + 1'b1;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic cfe_out_t close_block();
    cfe_out_t w;
    w = make_write(slot_idx, blk_code, 1'b0, '0);
    slot_idx = wr_idx;
    bump_index();
    blk_code = CODE_START;
    return w;
  endfunction

  function automatic void clear_frame();
    wr_idx   = IDX_W'(1);
    slot_idx = '0;
    blk_code = CODE_START;
    ovf_seen = 1'b0;
  endfunction

  task automatic encode_beat(input cfe_in_t b);
    cfe_out_t w[3];
    int       n;
    n = 0;
    if (b.data_byte == 8'h00) begin
      w[n] = close_block();
      n++;
    end else begin
      w[n] = make_write(wr_idx, b.data_byte, 1'b0, '0);
      n++;
      bump_index();
      blk_code = blk_code + 1'b1;
      if (blk_code == CODE_FULL) begin
        w[n] = close_block();
        n++;
      end
    end
    if (b.final_byte) begin
      w[n] = make_write(slot_idx, blk_code, 1'b1, wr_idx);
      n++;
      if (ovf_seen) overflow_frames++;
      clear_frame();
    end
    w[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) expected_writes.push_back(w[i]);
  endtask

  task automatic check_write(input cfe_out_t got);
    cfe_out_t want;
    if (expected_writes.size() == 0) begin
      $error("unexpected write: addr %0d byte %0h", got.write_addr, got.write_byte);
      fail_count++;
    end else begin
      want = expected_writes.pop_front();
      writes_checked++;
      if (got.write_addr !== want.write_addr) begin
        $error("write_addr: expected %0d, got %0d", want.write_addr, got.write_addr);
        fail_count++;
      end
      if (got.write_byte !== want.write_byte) begin
        $error("write_byte: expected %0h, got %0h", want.write_byte, got.write_byte);
        fail_count++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
        fail_count++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
        fail_count++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        fail_count++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      expected_writes.delete();
      fail_count      = 0;
      writes_checked  = 0;
      overflow_frames = 0;
    end else begin
      if (in_valid && !in_stall) encode_beat(in_data);
      if (out_valid && !out_stall) check_write(out_data);
    end
    writes_pending = expected_writes.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the COBS frame encoder bench: clock, reset, byte-frame stimulus and
// output backpressure. Depends on cfe_pkg, cobs_frame_encoder_core, cfe_write_checker.
`timescale 1ns / 1ps

module tb;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  cfe_pkg::cfe_in_t  in_data   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  cfe_pkg::cfe_out_t out_data;

  int fail_count;
  int writes_pending;
  int writes_checked;
  int overflow_frames;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int hold_left     = 0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;

  always #5 clk = ~clk;

  cobs_frame_encoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  cfe_write_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .writes_pending (writes_pending),
    .writes_checked (writes_checked),
    .overflow_frames(overflow_frames)
  );

  // receiver: random stall, plus one long hold-off to back the encoder up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // valid stays up from one beat to the next unless the sender idles
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, final_byte: fin};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (fin) frames_sent++;
  endtask

  task automatic send_frame(input int len, input int zero_pct, input bit no_zero);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if (no_zero) d = 8'($urandom_range(1, 255));
      else if ($urandom_range(99) < zero_pct) d = 8'h00;
      else d = 8'($urandom_range(255));
      send_byte(d, i == len - 1);
    end
  endtask

  task automatic random_frames(input int n_bytes);
    int target;
    int zp;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      case ($urandom_range(2))
        0: zp = 10;
        1: zp = 35;
        default: zp = 75;
      endcase
      send_frame($urandom_range(1, 12), zp, 1'b0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 72;
    // lone zero, lone 0xFF, lone 0x01
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    // alternating bit patterns
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    // back-to-back zeros, then data
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b1);
    // frame ending on a zero
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);
    // zero after data mid-frame
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    random_frames(10);

    send_idle_pct = 72;
    recv_idle_pct = 36;
    random_frames(10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    random_frames(5);
    // block fills to 0xFF exactly on the last byte
    send_frame(254, 0, 1'b1);
    random_frames(5);
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d bytes in %0d frames, %0d writes checked, %0d frames overflowed",
             bytes_sent, frames_sent, writes_checked, overflow_frames);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
